FILE: rtl/quadtree_bitmap_decoder_macros.svh
// ----------------------------------------------------------------------------
// Quadtree bitmap decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_BITMAP_DECODER_MACROS_SVH
`define QUADTREE_BITMAP_DECODER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define QTBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must be followed in the next cycle by a consequence.
`define QTBD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qtbd_pkg.sv
// ----------------------------------------------------------------------------
// Quadtree bitmap decoder package
// Shared widths, character codes, fault codes and the result record.
// ----------------------------------------------------------------------------
package qtbd_pkg;

    localparam int SYM_W   = 8;
    localparam int COORD_W = 10;
    localparam int LOG2_W  = 4;
    localparam int CNT_W   = 3;

    // Characters of the quadtree string.
    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] SYM_ONE   = 8'h31;

    // Image size limits and reset value of the side register.
    localparam logic [LOG2_W-1:0] SIDE_LOG2_MAX   = 4'd10;
    localparam logic [LOG2_W-1:0] SIDE_LOG2_RESET = 4'd10;

    // A complete node has this many children.
    localparam logic [CNT_W-1:0] CHILDREN = 3'd4;

    typedef enum logic [2:0] {
        FAULT_NONE      = 3'd0,
        FAULT_TOO_DEEP  = 3'd1,
        FAULT_FIFTH     = 3'd2,
        FAULT_BAD_CLOSE = 3'd3,
        FAULT_SUB_PIXEL = 3'd4
    } t_fault;

    typedef struct packed {
        logic               fill_valid;
        logic [COORD_W-1:0] block_row;
        logic [COORD_W-1:0] block_col;
        logic [LOG2_W-1:0]  block_log2;
        logic               fill_value;
        logic               tree_done;
        t_fault             fault;
    } t_result;

endpackage

FILE: rtl/qtbd_in_reg.sv
// ----------------------------------------------------------------------------
// Quadtree bitmap decoder input register
// Holds one accepted character until the decode stage takes it.
// ----------------------------------------------------------------------------
module qtbd_in_reg
    import qtbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_drain,
    input  logic [SYM_W-1:0] i_symbol,
    output logic             o_valid,
    output logic [SYM_W-1:0] o_symbol
);

    logic             r_valid;
    logic [SYM_W-1:0] r_symbol;

    // A new transfer refills the stage; otherwise a drain empties it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_symbol <= i_symbol;
        end
    end

    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;

endmodule

FILE: rtl/qtbd_core.sv
// ----------------------------------------------------------------------------
// Quadtree bitmap decoder core
// Level and child-count stack, and the decode of one character against them.
// ----------------------------------------------------------------------------
module qtbd_core
    import qtbd_pkg::*;
#(
    parameter int MAX_LEVELS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [LOG2_W-1:0] i_side_log2,
    output t_result           o_result
);

    localparam int LVW  = $clog2(MAX_LEVELS + 1);
    localparam int IDXW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CMPW = (LVW > LOG2_W) ? LVW : LOG2_W;

    logic [LVW-1:0]   r_level;
    logic [CNT_W-1:0] r_top;
    logic [CNT_W-1:0] r_stack [MAX_LEVELS];

    logic [LVW-1:0]    n_level;
    logic [CNT_W-1:0]  n_top;
    logic              wr_en;
    logic [IDXW-1:0]   wr_idx;
    logic [CNT_W-1:0]  wr_data;
    logic [IDXW-1:0]   top_idx;
    logic [IDXW-1:0]   push_idx;
    logic [IDXW-1:0]   par_idx;
    logic [CNT_W-1:0]  parent_cnt;
    logic [LOG2_W-1:0] sl;
    logic              lv_zero;
    logic              lv_full;
    logic              top_full;
    logic              too_small;
    logic [COORD_W-1:0] pos_row;
    logic [COORD_W-1:0] pos_col;
    t_result           res;

    // Stack addressing: the open node, the next free slot and the parent.
    assign top_idx    = IDXW'(r_level - LVW'(1));
    assign push_idx   = IDXW'(r_level);
    assign par_idx    = IDXW'(r_level - LVW'(2));
    assign parent_cnt = r_stack[par_idx];

    // Sides above the largest image act as the largest image.
    assign sl = (i_side_log2 > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : i_side_log2;

    assign lv_zero   = (r_level == '0);
    assign lv_full   = (r_level == LVW'(MAX_LEVELS));
    assign top_full  = !lv_zero && (r_top >= CHILDREN);
    assign too_small = CMPW'(r_level) > CMPW'(sl);

    // Block position: each open level adds one row and one column bit,
    // taken from the index of the child in progress at that level.
    always_comb begin
        logic [CNT_W-1:0] q;
        pos_row = '0;
        pos_col = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            q = r_stack[i];
            for (int b = 0; b < COORD_W; b++) begin
                if ((i < int'(r_level)) && (int'(sl) == i + 1 + b)) begin
                    if (q == 3'd0 || q == 3'd3) begin
                        pos_col[b] = 1'b1;
                    end
                    if (q == 3'd2 || q == 3'd3) begin
                        pos_row[b] = 1'b1;
                    end
                end
            end
        end
    end

    // Character decode and next state.
    always_comb begin
        n_level = r_level;
        n_top   = r_top;
        wr_en   = 1'b0;
        wr_idx  = top_idx;
        wr_data = '0;
        res     = '0;
        res.fault = FAULT_NONE;
        case (i_symbol)
            SYM_CLOSE: begin
                if (lv_zero) begin
                    res.fault = FAULT_BAD_CLOSE;
                end else begin
                    if (r_top != CHILDREN) begin
                        res.fault = FAULT_BAD_CLOSE;
                    end
                    n_level = r_level - LVW'(1);
                    if (r_level == LVW'(1)) begin
                        res.tree_done = 1'b1;
                        n_top         = '0;
                    end else begin
                        // The closed node counts as one child of its parent.
                        n_top   = (parent_cnt < CHILDREN) ? parent_cnt + CNT_W'(1)
                                                          : parent_cnt;
                        wr_en   = 1'b1;
                        wr_idx  = par_idx;
                        wr_data = n_top;
                    end
                end
            end
            SYM_OPEN: begin
                if (top_full) begin
                    res.fault = FAULT_FIFTH;
                end else if (lv_full) begin
                    res.fault = FAULT_TOO_DEEP;
                end else begin
                    n_level = r_level + LVW'(1);
                    n_top   = '0;
                    wr_en   = 1'b1;
                    wr_idx  = push_idx;
                    wr_data = '0;
                end
            end
            default: begin
                if (top_full) begin
                    res.fault = FAULT_FIFTH;
                end else begin
                    res.tree_done = lv_zero;
                    if (!lv_zero) begin
                        n_top   = r_top + CNT_W'(1);
                        wr_en   = 1'b1;
                        wr_idx  = top_idx;
                        wr_data = n_top;
                    end
                    if (too_small) begin
                        res.fault = FAULT_SUB_PIXEL;
                    end else begin
                        res.fill_valid = 1'b1;
                        res.block_row  = pos_row;
                        res.block_col  = pos_col;
                        res.block_log2 = sl - LOG2_W'(r_level);
                        res.fill_value = (i_symbol == SYM_ONE);
                    end
                end
            end
        endcase
    end

    // State registers advance once per decoded character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_top   <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_stack[i] <= '0;
            end
        end else if (i_fire) begin
            r_level <= n_level;
            r_top   <= n_top;
            if (wr_en) begin
                r_stack[wr_idx] <= wr_data;
            end
        end
    end

    assign o_result = res;

endmodule

FILE: rtl/qtbd_out_reg.sv
// ----------------------------------------------------------------------------
// Quadtree bitmap decoder result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module qtbd_out_reg
    import qtbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_stall,
    input  t_result i_result,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // A load refills the register; a completed transfer empties it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/quadtree_bitmap_decoder.sv
// ----------------------------------------------------------------------------
// Quadtree bitmap decoder
// Decodes a parenthesized quadtree string into leaf blocks, one per character.
// ----------------------------------------------------------------------------
// The block takes one character per clock and returns one result per
// character: the character is captured in an input register, decoded
// against the level counter and the child-count stack (kept in flip-flops,
// MAX_LEVELS entries of three bits), and the result is captured in an
// output register. A stall on the output holds the result and backs up into
// the input stall; otherwise the throughput is one character per cycle.
// Leaves report row, column, log2 side and fill value of their block;
// open/close characters report only tree completion and faults.
// The side register is taken at any time by a write transfer and should be
// changed only while no character is in flight.
module quadtree_bitmap_decoder
    import qtbd_pkg::*;
#(
    parameter int MAX_LEVELS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LOG2_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_fill_valid,
    output logic [COORD_W-1:0] o_block_row,
    output logic [COORD_W-1:0] o_block_col,
    output logic [LOG2_W-1:0]  o_block_log2,
    output logic               o_fill_value,
    output logic               o_tree_done,
    output logic [2:0]         o_fault
);

    `include "quadtree_bitmap_decoder_macros.svh"

    logic [LOG2_W-1:0] r_side_log2;
    logic              in_vld;
    logic [SYM_W-1:0]  in_sym;
    logic              out_ready;
    logic              in_accept;
    logic              fire;
    t_result           core_res;
    t_result           out_res;

    // Side register; the port always takes a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_log2 <= SIDE_LOG2_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_side_log2 <= i_cfg_data;
        end
    end

    // Pipeline handshake: decode whenever the result register can take it.
    assign out_ready  = !o_out_valid || !i_out_stall;
    assign fire       = in_vld && out_ready;
    assign o_in_stall = in_vld && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    qtbd_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_drain  (fire),
        .i_symbol (i_symbol),
        .o_valid  (in_vld),
        .o_symbol (in_sym)
    );

    qtbd_core #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_symbol    (in_sym),
        .i_side_log2 (r_side_log2),
        .o_result    (core_res)
    );

    qtbd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_stall  (i_out_stall),
        .i_result (core_res),
        .o_valid  (o_out_valid),
        .o_result (out_res)
    );

    // Result fields.
    assign o_fill_valid = out_res.fill_valid;
    assign o_block_row  = out_res.block_row;
    assign o_block_col  = out_res.block_col;
    assign o_block_log2 = out_res.block_log2;
    assign o_fill_value = out_res.fill_value;
    assign o_tree_done  = out_res.tree_done;
    assign o_fault      = out_res.fault;

    // Checks on the pipeline and on result consistency.
    `QTBD_ASSERT_NEXT(a_fire_gives_result, fire, o_out_valid, "decoded character lost")
    `QTBD_ASSERT(a_stall_only_when_full, o_in_stall |-> in_vld, "stall with empty input stage")
    `QTBD_ASSERT(a_leaf_no_fault, (o_out_valid && o_fill_valid) |-> (o_fault == FAULT_NONE), "leaf block reported with a fault")

endmodule
